// File: hdl/beam_request_spacing_stats_macros.svh
// Assertion macros shared by the beam request spacing statistics modules.
`ifndef BEAM_REQUEST_SPACING_STATS_MACROS_SVH
`define BEAM_REQUEST_SPACING_STATS_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BRSS_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("brss assertion failed");

// Condition in one cycle implies the consequence in the next.
`define BRSS_ASSERT_NEXT(name, cond, nxt) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("brss sequence assertion failed");

`endif

// File: hdl/brss_pkg.sv
// Shared constants, types and helpers for the beam request spacing statistics block.
`timescale 1ns / 1ps
package brss_pkg;

    localparam int DESTINATIONS = 16;
    localparam int ENGINES      = 4;
    localparam int CONTROL_BITS = 16;
    localparam int BUCKET_BITS  = 20;

    localparam int TABLE_SIZE = DESTINATIONS + ENGINES * CONTROL_BITS;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int STAT_W     = BUCKET_BITS + 1;
    localparam int FIELD_W    = 21;
    localparam int COUNT_W    = 21;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(1) << 20;

    typedef enum logic [1:0] {
        OP_FRAME   = 2'd0,
        OP_CONTROL = 2'd1,
        OP_READ    = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    localparam logic REG_NO_DEST  = 1'b0;
    localparam logic REG_CHECK_EN = 1'b1;

    typedef logic signed [STAT_W-1:0] stat_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        stat_t              min_sp;
        stat_t              max_sp;
        stat_t              first_bk;
        stat_t              last_bk;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        count:    '0,
        min_sp:   '1,
        max_sp:   '1,
        first_bk: '1,
        last_bk:  '1
    };

    typedef struct packed {
        logic accept;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
    } sts_t;

    // Sign-extend or truncate a stored statistic to the result field width.
    function automatic logic [FIELD_W-1:0] to_field(input stat_t v);
        logic signed [63:0] w;
        begin
            w = 64'(v);
            return w[FIELD_W-1:0];
        end
    endfunction

endpackage

// File: hdl/brss_ctrl.sv
// Controller state machine: accepts commands, sequences the bit scan, strobes results.
`timescale 1ns / 1ps
`include "beam_request_spacing_stats_macros.svh"
module brss_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       opcode,
    input  brss_pkg::sts_t   sts,
    output brss_pkg::cmd_t   cmd,
    output logic             busy,
    output logic             done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    state_t state_reg;
    logic   done_reg;
    logic   short_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_FIN);
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (opcode == brss_pkg::OP_FRAME || opcode == brss_pkg::OP_CONTROL)
                            state_reg <= ST_SCAN;
                        else
                            state_reg <= ST_FIN;
                    end
                end
                ST_SCAN:
                begin
                    if (sts.scan_last)
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.accept = start && (state_reg == ST_IDLE);
        cmd.step   = (state_reg == ST_SCAN);
        cmd.finish = (state_reg == ST_FIN);
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    // read and clear need no scan
    assign short_op = (opcode == brss_pkg::OP_READ) || (opcode == brss_pkg::OP_CLEAR);

    `BRSS_ASSERT_NEXT(a_done_single_beat, done_reg, !done_reg)
    `BRSS_ASSERT_NEXT(a_fin_gives_done, state_reg == ST_FIN, done_reg && state_reg == ST_IDLE)
    `BRSS_ASSERT_NEXT(a_short_ops_skip_scan, start && !busy && short_op, state_reg == ST_FIN)

endmodule

// File: hdl/brss_dp.sv
// Datapath: config registers, bucket tracking, statistics table and result registers.
`timescale 1ns / 1ps
`include "beam_request_spacing_stats_macros.svh"
module brss_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  brss_pkg::cmd_t                      cmd,
    output brss_pkg::sts_t                      sts,
    input  logic [1:0]                          opcode,
    input  logic                                first_frame,
    input  logic [63:0]                         pulse_id,
    input  logic                                beam_request,
    input  logic [3:0]                          destination,
    input  logic [7:0]                          expected_destination,
    input  logic [1:0]                          engine,
    input  logic [15:0]                         control_word,
    input  logic [15:0]                         expected_control,
    input  logic [6:0]                          read_index,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [7:0]                          cfg_data,
    output logic                                mismatch,
    output logic                                entry_used,
    output logic [brss_pkg::COUNT_W-1:0]        request_count,
    output logic signed [brss_pkg::FIELD_W-1:0] min_spacing,
    output logic signed [brss_pkg::FIELD_W-1:0] max_spacing,
    output logic signed [brss_pkg::FIELD_W-1:0] first_bucket,
    output logic signed [brss_pkg::FIELD_W-1:0] last_bucket
);

    localparam int BB = brss_pkg::BUCKET_BITS;
    localparam int AW = brss_pkg::ADDR_W;
    localparam int CB = brss_pkg::CONTROL_BITS;

    // Configuration
    logic [7:0]         no_dest_reg;
    logic               check_en_reg;

    // Record timing
    logic [63:0]        base_reg;
    logic [BB-1:0]      bucket_reg;

    // Item state
    brss_pkg::op_t      op_reg;
    logic               mismatch_reg;
    logic               rd_in_range_reg;
    logic [CB-1:0]      mask_reg;
    logic [AW-1:0]      scan_addr_reg;

    // Read-modify-write pipeline
    logic               upd_valid_reg;
    logic [AW-1:0]      upd_addr_reg;
    brss_pkg::entry_t   rd_data_reg;
    logic               rd_vld_reg;
    logic [brss_pkg::TABLE_SIZE-1:0] vld_reg;
    brss_pkg::entry_t   mem [brss_pkg::TABLE_SIZE];

    // Result registers
    logic                           mismatch_out_reg;
    logic                           used_out_reg;
    logic [brss_pkg::COUNT_W-1:0]   count_out_reg;
    logic [brss_pkg::FIELD_W-1:0]   min_out_reg;
    logic [brss_pkg::FIELD_W-1:0]   max_out_reg;
    logic [brss_pkg::FIELD_W-1:0]   first_out_reg;
    logic [brss_pkg::FIELD_W-1:0]   last_out_reg;

    brss_pkg::op_t      op_in;
    logic [63:0]        base_sel;
    logic [BB-1:0]      bucket_in;
    logic [7:0]         eff_dest;
    logic               frame_mis;
    logic               eng_ok;
    logic               ctrl_mis;
    logic               dest_ok;
    logic               idx_ok;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    brss_pkg::entry_t   cur;
    brss_pkg::entry_t   upd;
    brss_pkg::stat_t    b_stat;
    brss_pkg::stat_t    sp;

    always_comb
    begin
        op_in     = brss_pkg::op_t'(opcode);
        base_sel  = first_frame ? pulse_id : base_reg;
        bucket_in = pulse_id[BB-1:0] - base_sel[BB-1:0];
        eff_dest  = beam_request ? 8'(destination) : no_dest_reg;
        frame_mis = check_en_reg && (eff_dest != expected_destination);
        eng_ok    = 32'(engine) < brss_pkg::ENGINES;
        ctrl_mis  = eng_ok && (control_word != expected_control);
        dest_ok   = beam_request && (32'(destination) < brss_pkg::DESTINATIONS);
        idx_ok    = 32'(read_index) < brss_pkg::TABLE_SIZE;

        rd_en   = 1'b0;
        rd_addr = scan_addr_reg;
        if (cmd.accept && op_in == brss_pkg::OP_READ && idx_ok)
        begin
            rd_en   = 1'b1;
            rd_addr = AW'(read_index);
        end
        else if (cmd.step && mask_reg[0])
        begin
            rd_en = 1'b1;
        end

        // Entry never written since the last clear reads as its reset value.
        cur    = rd_vld_reg ? rd_data_reg : brss_pkg::ENTRY_RESET;
        b_stat = brss_pkg::stat_t'({1'b0, bucket_reg});
        sp     = brss_pkg::stat_t'({1'b0, bucket_reg - cur.last_bk[BB-1:0]});

        upd = cur;
        if (cur.count < brss_pkg::COUNT_MAX)
            upd.count = cur.count + brss_pkg::COUNT_W'(1);
        if (!cur.first_bk[brss_pkg::STAT_W-1])
        begin
            if (cur.min_sp[brss_pkg::STAT_W-1] || ($signed(sp) < $signed(cur.min_sp)))
                upd.min_sp = sp;
            if ($signed(sp) > $signed(cur.max_sp))
                upd.max_sp = sp;
        end
        else
        begin
            upd.first_bk = b_stat;
        end
        upd.last_bk = b_stat;

        sts.scan_last = ((mask_reg >> 1) == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_dest_reg     <= 8'hFF;
            check_en_reg    <= 1'b1;
            base_reg        <= '0;
            bucket_reg      <= '0;
            op_reg          <= brss_pkg::OP_FRAME;
            mismatch_reg    <= 1'b0;
            rd_in_range_reg <= 1'b0;
            mask_reg        <= '0;
            scan_addr_reg   <= '0;
            upd_valid_reg   <= 1'b0;
            upd_addr_reg    <= '0;
            vld_reg         <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    brss_pkg::REG_NO_DEST:  no_dest_reg  <= cfg_data;
                    brss_pkg::REG_CHECK_EN: check_en_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            upd_valid_reg <= cmd.step && mask_reg[0];

            if (cmd.accept)
            begin
                op_reg          <= op_in;
                rd_in_range_reg <= idx_ok;
                case (op_in)
                    brss_pkg::OP_FRAME:
                    begin
                        if (first_frame)
                            base_reg <= pulse_id;
                        bucket_reg    <= bucket_in;
                        mismatch_reg  <= frame_mis;
                        mask_reg      <= CB'(dest_ok);
                        scan_addr_reg <= AW'(destination);
                    end
                    brss_pkg::OP_CONTROL:
                    begin
                        mismatch_reg  <= ctrl_mis;
                        mask_reg      <= eng_ok ? control_word[CB-1:0] : '0;
                        scan_addr_reg <= AW'(brss_pkg::DESTINATIONS
                                             + 32'(engine) * brss_pkg::CONTROL_BITS);
                    end
                    default:
                    begin
                        mismatch_reg <= 1'b0;
                        mask_reg     <= '0;
                    end
                endcase
            end
            else if (cmd.step)
            begin
                mask_reg      <= mask_reg >> 1;
                scan_addr_reg <= scan_addr_reg + AW'(1);
                upd_addr_reg  <= scan_addr_reg;
            end

            if (cmd.accept && op_in == brss_pkg::OP_CLEAR)
                vld_reg <= '0;
            else if (upd_valid_reg)
                vld_reg[upd_addr_reg] <= 1'b1;
        end
    end

    // Table storage: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (upd_valid_reg)
            mem[upd_addr_reg] <= upd;
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            mismatch_out_reg <= mismatch_reg;
            if (op_reg == brss_pkg::OP_READ && rd_in_range_reg)
            begin
                used_out_reg  <= (cur.count != '0);
                count_out_reg <= cur.count;
                min_out_reg   <= brss_pkg::to_field(cur.min_sp);
                max_out_reg   <= brss_pkg::to_field(cur.max_sp);
                first_out_reg <= brss_pkg::to_field(cur.first_bk);
                last_out_reg  <= brss_pkg::to_field(cur.last_bk);
            end
            else if (op_reg == brss_pkg::OP_READ)
            begin
                used_out_reg  <= 1'b0;
                count_out_reg <= '0;
                min_out_reg   <= '1;
                max_out_reg   <= '1;
                first_out_reg <= '1;
                last_out_reg  <= '1;
            end
            else
            begin
                used_out_reg  <= 1'b0;
                count_out_reg <= '0;
                min_out_reg   <= '0;
                max_out_reg   <= '0;
                first_out_reg <= '0;
                last_out_reg  <= '0;
            end
        end
    end

    assign mismatch      = mismatch_out_reg;
    assign entry_used    = used_out_reg;
    assign request_count = count_out_reg;
    assign min_spacing   = min_out_reg;
    assign max_spacing   = max_out_reg;
    assign first_bucket  = first_out_reg;
    assign last_bucket   = last_out_reg;

    `BRSS_ASSERT(a_no_write_pending_on_accept, upd_valid_reg |-> !cmd.accept)
    `BRSS_ASSERT(a_mask_drained_at_finish, cmd.finish |-> mask_reg == '0)
    `BRSS_ASSERT(a_write_in_table, upd_valid_reg |-> 32'(upd_addr_reg) < brss_pkg::TABLE_SIZE)

endmodule

// File: hdl/beam_request_spacing_stats.sv
// Top level: beam request spacing statistics with destination and control word checks.
// Usage:
//   Commands enter on start while busy is low; opcode selects a frame check, an
//   engine control word check, an entry read or a table clear. Fields not used
//   by the opcode are ignored. Each command gives exactly one result beat, shown
//   for one cycle with done high; the receiver cannot stall, so it must take
//   the beat in that cycle.
//   Read and clear go from the accepting edge straight to the finish state;
//   frame and control commands first scan up to the highest counted set bit
//   (at least bit 0, at most bit 15). done is registered from the finish state.
//   The table is one memory with a registered read; the scan visits one control
//   bit per cycle and the read-modify-write of each set bit overlaps the next read.
//   A new command may be accepted in the cycle that done is high.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
//   and are expected only while the block is idle.
//   Reset: configuration returns to its defaults, the base pulse id and current
//   bucket go to zero and every table entry reads as empty (count 0, -1 else).
`timescale 1ns / 1ps
module beam_request_spacing_stats
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          opcode,
    input  logic                                first_frame,
    input  logic [63:0]                         pulse_id,
    input  logic                                beam_request,
    input  logic [3:0]                          destination,
    input  logic [7:0]                          expected_destination,
    input  logic [1:0]                          engine,
    input  logic [15:0]                         control_word,
    input  logic [15:0]                         expected_control,
    input  logic [6:0]                          read_index,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [7:0]                          cfg_data,
    output logic                                done,
    output logic                                mismatch,
    output logic                                entry_used,
    output logic [brss_pkg::COUNT_W-1:0]        request_count,
    output logic signed [brss_pkg::FIELD_W-1:0] min_spacing,
    output logic signed [brss_pkg::FIELD_W-1:0] max_spacing,
    output logic signed [brss_pkg::FIELD_W-1:0] first_bucket,
    output logic signed [brss_pkg::FIELD_W-1:0] last_bucket
);

    brss_pkg::cmd_t cmd;
    brss_pkg::sts_t sts;

    brss_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    brss_dp u_dp
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .sts                  (sts),
        .opcode               (opcode),
        .first_frame          (first_frame),
        .pulse_id             (pulse_id),
        .beam_request         (beam_request),
        .destination          (destination),
        .expected_destination (expected_destination),
        .engine               (engine),
        .control_word         (control_word),
        .expected_control     (expected_control),
        .read_index           (read_index),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .mismatch             (mismatch),
        .entry_used           (entry_used),
        .request_count        (request_count),
        .min_spacing          (min_spacing),
        .max_spacing          (max_spacing),
        .first_bucket         (first_bucket),
        .last_bucket          (last_bucket)
    );

endmodule

// File: tb/sv/tb_beam_request_spacing_stats.sv
// Self-checking testbench for the beam request spacing statistics block.
`timescale 1ns / 1ps
module tb_beam_request_spacing_stats;

    localparam int LIMIT_CYCLES = 400000;
    localparam int BKW = brss_pkg::BUCKET_BITS;
    localparam int CW  = brss_pkg::COUNT_W;
    localparam int FW  = brss_pkg::FIELD_W;
    localparam int TS  = brss_pkg::TABLE_SIZE;

    typedef struct {
        brss_pkg::op_t op;
        bit         first;
        bit [63:0]  pid;
        bit         req;
        bit [3:0]   dst;
        bit [7:0]   exp_dst;
        bit [1:0]   eng;
        bit [15:0]  word;
        bit [15:0]  exp_word;
        bit [6:0]   idx;
    } beam_cmd_t;

    typedef struct {
        bit          flag;
        bit          used;
        bit [CW-1:0] count;
        bit [FW-1:0] min_sp;
        bit [FW-1:0] max_sp;
        bit [FW-1:0] first_bk;
        bit [FW-1:0] last_bk;
    } stats_beat_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [1:0]                  opcode = '0;
    logic                        first_frame = 1'b0;
    logic [63:0]                 pulse_id = '0;
    logic                        beam_request = 1'b0;
    logic [3:0]                  destination = '0;
    logic [7:0]                  expected_destination = '0;
    logic [1:0]                  engine = '0;
    logic [15:0]                 control_word = '0;
    logic [15:0]                 expected_control = '0;
    logic [6:0]                  read_index = '0;
    logic                        cfg_write = 1'b0;
    logic                        cfg_index = 1'b0;
    logic [7:0]                  cfg_data = '0;
    logic                        done;
    logic                        mismatch;
    logic                        entry_used;
    logic [CW-1:0]               request_count;
    logic signed [FW-1:0]        min_spacing;
    logic signed [FW-1:0]        max_spacing;
    logic signed [FW-1:0]        first_bucket;
    logic signed [FW-1:0]        last_bucket;

    beam_request_spacing_stats dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .first_frame(first_frame), .pulse_id(pulse_id),
        .beam_request(beam_request), .destination(destination),
        .expected_destination(expected_destination), .engine(engine),
        .control_word(control_word), .expected_control(expected_control),
        .read_index(read_index), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .mismatch(mismatch),
        .entry_used(entry_used), .request_count(request_count),
        .min_spacing(min_spacing), .max_spacing(max_spacing),
        .first_bucket(first_bucket), .last_bucket(last_bucket)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // shadow of the block: registers, record base, statistics table
    bit [7:0]               no_dest_code = 8'd255;
    bit                     check_en = 1'b1;
    bit [63:0]              base_pid = '0;
    bit [BKW-1:0]           cur_bucket = '0;
    int unsigned            count_tab [TS];
    longint                 min_tab [TS];
    longint                 max_tab [TS];
    longint                 first_tab [TS];
    longint                 last_tab [TS];

    beam_cmd_t   pending [$];
    stats_beat_t expected_stats [$];
    int          queued = 0;
    int          fails = 0;
    int          cycles = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          n_frame = 0, n_control = 0, n_read = 0, n_clear = 0;
    int          n_flagged = 0, n_populated = 0;
    beam_cmd_t   issued;
    stats_beat_t predicted;
    stats_beat_t seen;
    bit [7:0]    code_plan [5] = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd255};
    bit          enable_plan [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    function automatic void clear_stats();
        for (int k = 0; k < TS; k++)
        begin
            count_tab[k] = 0;
            min_tab[k] = -1;
            max_tab[k] = -1;
            first_tab[k] = -1;
            last_tab[k] = -1;
        end
    endfunction

    function automatic void note_request(input int k, input bit [BKW-1:0] bucket);
        bit [BKW-1:0] spacing;
        if (k >= TS)
            return;
        if (count_tab[k] < brss_pkg::COUNT_MAX)
            count_tab[k]++;
        if (first_tab[k] < 0)
            first_tab[k] = longint'(bucket);
        else
        begin
            // modular distance, never negative
            spacing = bucket - BKW'(last_tab[k]);
            if (min_tab[k] < 0 || longint'(spacing) < min_tab[k])
                min_tab[k] = longint'(spacing);
            if (longint'(spacing) > max_tab[k])
                max_tab[k] = longint'(spacing);
        end
        last_tab[k] = longint'(bucket);
    endfunction

    function automatic stats_beat_t apply_command(input beam_cmd_t c);
        stats_beat_t r;
        bit [7:0]    eff;
        int          k;
        r = '{default: '0};
        case (c.op)
            brss_pkg::OP_FRAME:
            begin
                eff = c.req ? {4'h0, c.dst} : no_dest_code;
                if (c.first)
                    base_pid = c.pid;
                cur_bucket = BKW'(c.pid - base_pid);
                r.flag = check_en && (eff != c.exp_dst);
                if (c.req && int'(c.dst) < brss_pkg::DESTINATIONS)
                    note_request(int'(c.dst), cur_bucket);
            end
            brss_pkg::OP_CONTROL:
            begin
                if (int'(c.eng) < brss_pkg::ENGINES)
                begin
                    r.flag = c.word != c.exp_word;
                    for (int b = 0; b < 16 && b < brss_pkg::CONTROL_BITS; b++)
                        if (c.word[b])
                            note_request(brss_pkg::DESTINATIONS
                                         + int'(c.eng) * brss_pkg::CONTROL_BITS + b,
                                         cur_bucket);
                end
            end
            brss_pkg::OP_READ:
            begin
                k = int'(c.idx);
                if (k < TS)
                begin
                    r.used = count_tab[k] != 0;
                    r.count = CW'(count_tab[k]);
                    r.min_sp = FW'(min_tab[k]);
                    r.max_sp = FW'(max_tab[k]);
                    r.first_bk = FW'(first_tab[k]);
                    r.last_bk = FW'(last_tab[k]);
                end
                else
                begin
                    r.min_sp = '1;
                    r.max_sp = '1;
                    r.first_bk = '1;
                    r.last_bk = '1;
                end
            end
            default:
                clear_stats();
        endcase
        return r;
    endfunction

    // every field random; each command kind then sets the ones it uses
    function automatic beam_cmd_t rand_cmd();
        beam_cmd_t c;
        c.op = brss_pkg::op_t'($urandom_range(0, 3));
        c.first = 1'($urandom);
        c.pid = {$urandom, $urandom};
        c.req = 1'($urandom);
        c.dst = 4'($urandom);
        c.exp_dst = 8'($urandom);
        c.eng = 2'($urandom);
        c.word = 16'($urandom);
        c.exp_word = 16'($urandom);
        c.idx = 7'($urandom);
        return c;
    endfunction

    task automatic queue_frame(input bit first, input bit [63:0] pid, input bit req,
                               input bit [3:0] dst, input bit [7:0] exp_dst);
        beam_cmd_t c;
        c = rand_cmd();
        c.op = brss_pkg::OP_FRAME;
        c.first = first;
        c.pid = pid;
        c.req = req;
        c.dst = dst;
        c.exp_dst = exp_dst;
        pending.insert(pending.size(), c);
        queued++;
    endtask

    task automatic queue_control(input bit [1:0] eng, input bit [15:0] word,
                                 input bit [15:0] exp_word);
        beam_cmd_t c;
        c = rand_cmd();
        c.op = brss_pkg::OP_CONTROL;
        c.eng = eng;
        c.word = word;
        c.exp_word = exp_word;
        pending.insert(pending.size(), c);
        queued++;
    endtask

    task automatic queue_read(input bit [6:0] idx);
        beam_cmd_t c;
        c = rand_cmd();
        c.op = brss_pkg::OP_READ;
        c.idx = idx;
        pending.insert(pending.size(), c);
        queued++;
    endtask

    task automatic queue_clear();
        beam_cmd_t c;
        c = rand_cmd();
        c.op = brss_pkg::OP_CLEAR;
        pending.insert(pending.size(), c);
        queued++;
    endtask

    task automatic write_reg(input logic idx, input bit [7:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == brss_pkg::REG_NO_DEST)
            no_dest_code = data;
        else
            check_en = data[0];
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // all beats accepted and answered, plus a few idle cycles
    task automatic drain();
        while (pending.size() != 0 || expected_stats.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic fill_random(input int target);
        bit [63:0] pid;
        bit [3:0]  dest_base;
        bit [3:0]  dst;
        bit [15:0] mask;
        bit [15:0] word;
        bit [15:0] want_word;
        bit [7:0]  want_dst;
        bit        req;
        int        frames;
        int        r;
        int        stop;
        beam_cmd_t c;
        stop = queued + target;
        while (queued < stop)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                // noise: any opcode, clears kept rare
                c = rand_cmd();
                if (c.op == brss_pkg::OP_CLEAR && $urandom_range(0, 3) != 0)
                    c.op = brss_pkg::OP_READ;
                pending.insert(pending.size(), c);
                queued++;
            end
            else
            begin
                pid = {$urandom, $urandom};
                dest_base = 4'($urandom);
                mask = 16'($urandom);
                frames = $urandom_range(2, 25);
                for (int f = 0; f < frames; f++)
                begin
                    if (f > 0)
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 70)
                            pid += 64'($urandom_range(1, 50));
                        else if (r < 85)
                            pid += 64'($urandom_range(0, 3));
                        else if (r < 95)
                            pid += 64'($urandom_range(1000, 300000));
                        else
                            pid += {$urandom, $urandom};
                    end
                    req = $urandom_range(0, 3) != 0;
                    if ($urandom_range(0, 3) == 0)
                        dst = 4'($urandom);
                    else
                        dst = dest_base + 4'($urandom_range(0, 2));
                    want_dst = req ? {4'h0, dst} : no_dest_code;
                    if ($urandom_range(0, 7) == 0)
                        want_dst = 8'($urandom);
                    queue_frame(f == 0, pid, req, dst, want_dst);
                    repeat ($urandom_range(0, 2))
                    begin
                        if ($urandom_range(0, 4) == 0)
                            word = 16'($urandom);
                        else
                            word = mask & 16'($urandom);
                        want_word = word;
                        if ($urandom_range(0, 7) == 0)
                            want_word = word ^ (16'h1 << $urandom_range(0, 15));
                        queue_control(2'($urandom), word, want_word);
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        r = $urandom_range(0, 9);
                        if (r < 4)
                            queue_read(7'(dst));
                        else if (r < 7)
                            queue_read(7'(16 + $urandom_range(0, 63)));
                        else if (r < 9)
                            queue_read(7'($urandom_range(0, 79)));
                        else
                            queue_read(7'($urandom_range(80, 127)));
                    end
                    if ($urandom_range(0, 199) == 0)
                        queue_clear();
                end
            end
        end
    endtask

    // command driver: bursts of beats separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                issued = pending[0];
                pending.delete(0);
                predicted = apply_command(issued);
                expected_stats.insert(expected_stats.size(), predicted);
                case (issued.op)
                    brss_pkg::OP_FRAME:   n_frame++;
                    brss_pkg::OP_CONTROL: n_control++;
                    brss_pkg::OP_READ:    n_read++;
                    default:              n_clear++;
                endcase
                if (predicted.flag)
                    n_flagged++;
                if (predicted.used)
                    n_populated++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else if (!start && gap_left > 0)
                gap_left--;
            if (gap_left == 0 && pending.size() != 0)
            begin
                start <= 1'b1;
                opcode <= pending[0].op;
                first_frame <= pending[0].first;
                pulse_id <= pending[0].pid;
                beam_request <= pending[0].req;
                destination <= pending[0].dst;
                expected_destination <= pending[0].exp_dst;
                engine <= pending[0].eng;
                control_word <= pending[0].word;
                expected_control <= pending[0].exp_word;
                read_index <= pending[0].idx;
            end
            else
                start <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [FW-1:0] want,
                               input logic [FW-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    // result monitor; done beats last one cycle and cannot be held off
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
        else if (rst_n && done)
        begin
            if (expected_stats.size() == 0)
            begin
                $error("result beat with no command outstanding");
                fails++;
            end
            else
            begin
                seen = expected_stats[0];
                expected_stats.delete(0);
                check_field("mismatch", FW'(seen.flag), FW'(mismatch));
                check_field("entry_used", FW'(seen.used), FW'(entry_used));
                check_field("request_count", seen.count, request_count);
                check_field("min_spacing", seen.min_sp, min_spacing);
                check_field("max_spacing", seen.max_sp, max_spacing);
                check_field("first_bucket", seen.first_bk, first_bucket);
                check_field("last_bucket", seen.last_bk, last_bucket);
            end
        end
    end

    initial
    begin
        clear_stats();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        // empty table, both ends and past the end
        queue_read(7'd0);
        queue_read(7'd79);
        queue_read(7'd127);
        // frame before any record start: base is still zero
        queue_frame(1'b0, 64'd5, 1'b1, 4'd3, 8'd3);
        queue_frame(1'b1, '1, 1'b1, 4'd15, 8'd15);
        queue_frame(1'b0, 64'd0, 1'b1, 4'd15, 8'd0);
        // no request: compared against the no-destination code
        queue_frame(1'b0, 64'd3, 1'b0, 4'd7, 8'd255);
        queue_frame(1'b0, 64'd3, 1'b0, 4'd7, 8'd0);
        queue_control(2'd0, 16'hFFFF, 16'hFFFF);
        queue_control(2'd3, 16'h8001, 16'h8000);
        queue_control(2'd1, 16'h0000, 16'h0000);
        // bucket wraps to zero: spacing from bucket 1 spans the whole range
        queue_frame(1'b0, 64'h0000_0000_000F_FFFF, 1'b1, 4'd15, 8'd15);
        queue_control(2'd3, 16'h8000, 16'h8000);
        queue_read(7'd15);
        queue_read(7'd16);
        queue_read(7'd79);
        queue_read(7'd64);
        queue_read(7'd3);
        queue_clear();
        queue_read(7'd15);
        queue_read(7'd79);
        queue_frame(1'b1, 64'd0, 1'b1, 4'd0, 8'd0);
        queue_read(7'd0);
        drain();

        code_plan[2] = 8'($urandom_range(1, 254));
        for (int p = 0; p < 5; p++)
        begin
            write_reg(brss_pkg::REG_NO_DEST, code_plan[p]);
            write_reg(brss_pkg::REG_CHECK_EN, {7'h0, enable_plan[p]});
            @(negedge clk);
            fill_random(365);
            drain();
        end

        repeat (30) @(posedge clk);
        $display("Ran %0d frames, %0d control words, %0d reads, %0d clears in 6 settings",
                 n_frame, n_control, n_read, n_clear);
        $display("%0d checks flagged a difference, %0d reads hit populated entries",
                 n_flagged, n_populated);
        if (fails == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
